// File: design/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, off while reset is asserted.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
	`SPQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: design/spq_pkg.sv
// Types, sizes and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH   = 8;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OCNT_W  = 4;
	localparam int STAT_W  = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;

	// Shift enables broadcast to every cell; the key travels on its own.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} spq_ctrl_t;

	// Compare results of one cell against the key.
	typedef struct packed {
		logic gt;   // empty or larger than key
		logic ge;   // live and not smaller than key
		logic eq;   // live and equal to key
	} spq_flags_t;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted list: holds an entry, compares it, shifts with neighbors.
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  spq_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0] key,
	input  logic                     live,
	input  logic                     left_gt,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic signed [DATA_W-1:0] right_value,
	output spq_flags_t               flags,
	output logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] value_nxt
);

	logic signed [DATA_W-1:0] value_q;

	always_comb begin
		flags.gt = !live || (value_q > key);
		flags.ge = live && (value_q >= key);
		flags.eq = live && (value_q == key);
	end

	// Insert: larger entries move right, the boundary cell takes the key.
	// Remove: entries from the match onward move left.
	always_comb begin
		value_nxt = value_q;
		priority if (ctrl.ins_en) begin
			if (flags.gt)
				value_nxt = left_gt ? left_value : key;
		end else if (ctrl.rem_en) begin
			if (flags.ge)
				value_nxt = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

	assign value = value_q;

endmodule

// File: design/sorted_priority_queue.sv
// Sorted priority queue top level: row of compare-and-shift cells plus result register.
//
// Keeps up to DEPTH signed 32-bit entries in ascending order in a row of cells.
// Every cell compares its entry with the incoming value in the same cycle, so an
// insert or a remove-by-value needs no search loop and a new transaction is
// taken every cycle while the result register is free or being drained. The
// result (status, entry count, smallest entry) appears the cycle after the input
// transaction is accepted. The longest path is one 32-bit compare per cell plus
// the OR over the cells' match flags and the shift select. Inserting into a full
// list is dropped with status 1; removing a value that is not held (or from an
// empty list) changes nothing and gives status 2. Equal values keep arrival order
// and a remove takes the oldest of them. No clearing pass is needed after reset:
// only cells below the entry count are ever read.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [OCNT_W-1:0]        entry_count,
	output logic                     head_valid,
	output logic signed [DATA_W-1:0] head_value
);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [OCNT_W-1:0]        entry_count_q;
	logic                     head_valid_q;
	logic signed [DATA_W-1:0] head_value_q;

	spq_ctrl_t                ctrl;
	spq_flags_t               flags     [DEPTH];
	logic signed [DATA_W-1:0] cell_val  [DEPTH];
	logic signed [DATA_W-1:0] cell_nxt  [DEPTH];
	logic [DEPTH-1:0]         live;
	logic [DEPTH-1:0]         eq_vec;

	logic                     accept;
	logic                     full;
	logic                     found;
	logic [STAT_W-1:0]        status_nxt;

	// Free output slot or one being taken this cycle lets the next transaction in.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign found = |eq_vec;

	always_comb begin
		ctrl.ins_en = accept && (cmd == CMD_INSERT) && !full;
		ctrl.rem_en = accept && (cmd == CMD_REMOVE) && found;
	end

	// Cell row. Cell 0 holds the smallest entry; the last cell has no right
	// neighbor and keeps its own value on a remove (it falls out of the live range).
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic                     l_gt;
		logic signed [DATA_W-1:0] l_val;
		logic signed [DATA_W-1:0] r_val;

		assign live[k]   = (CNT_W'(k) < count_q);
		assign eq_vec[k] = flags[k].eq;

		if (k == 0) begin : g_first
			assign l_gt  = 1'b0;
			assign l_val = cell_val[k];
		end else begin : g_mid
			assign l_gt  = flags[k-1].gt;
			assign l_val = cell_val[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign r_val = cell_val[k];
		end else begin : g_inner
			assign r_val = cell_val[k+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.key         (value),
			.live        (live[k]),
			.left_gt     (l_gt),
			.left_value  (l_val),
			.right_value (r_val),
			.flags       (flags[k]),
			.value       (cell_val[k]),
			.value_nxt   (cell_nxt[k])
		);
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		priority if (ctrl.ins_en) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.rem_en) begin
			count_nxt = count_q - CNT_W'(1);
		end else if (cmd == CMD_INSERT) begin
			status_nxt = ST_FULL;
		end else begin
			status_nxt = ST_NOMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_nxt;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload, captured from the post-transaction state.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nxt;
			entry_count_q <= OCNT_W'(count_nxt);
			head_valid_q  <= (count_nxt != '0);
			head_value_q  <= (count_nxt != '0) ? cell_nxt[0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign head_valid  = head_valid_q;
	assign head_value  = head_value_q;

endmodule

// File: design/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [STAT_W-1:0]        status,
	input logic [OCNT_W-1:0]        entry_count,
	input logic                     head_valid,
	input logic signed [DATA_W-1:0] head_value
);

	// A stalled result holds its payload.
	`SPQ_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(status) && $stable(head_value)), "result changed while stalled")

	// Input is taken whenever the result slot is empty.
	`SPQ_ASSERT_IMP(a_ready_free, !out_valid, in_ready, "input blocked with empty result slot")

	// An empty list reports a zero head and cannot have dropped an insert.
	`SPQ_ASSERT_IMP(a_empty_head, out_valid && !head_valid, (head_value == '0) && (status != ST_FULL), "empty list with head or full status")

	// A dropped insert means the list is nonempty and status is a known code.
	`SPQ_ASSERT_IMP(a_status_code, out_valid, (status == ST_DONE) || (status == ST_NOMATCH) || ((status == ST_FULL) && head_valid), "bad status")

	// Count stays within the list size and agrees with the head flag.
	`SPQ_ASSERT_IMP(a_count_head, out_valid, (entry_count <= OCNT_W'(DEPTH)) && (head_valid == (entry_count != '0)), "bad count")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.entry_count (entry_count),
	.head_valid  (head_valid),
	.head_value  (head_value)
);

// File: bench/tb.sv
// Self-checking bench for the sorted priority queue: directed and random insert/remove traffic.
module tb;
	import spq_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = CMD_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STAT_W-1:0]        status;
	logic [OCNT_W-1:0]        entry_count;
	logic                     head_valid;
	logic signed [DATA_W-1:0] head_value;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [OCNT_W-1:0]        entry_count;
		logic                     head_valid;
		logic signed [DATA_W-1:0] head_value;
	} queue_result_t;

	// Mirror of the sorted list plus the results still owed by the block.
	class spq_scoreboard;
		logic signed [DATA_W-1:0] held[DEPTH];
		int                       held_n;
		queue_result_t            awaited[$];
		int                       errors;

		function new();
			held_n = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Apply one accepted transaction to the mirror and queue its result.
		function void note_request(logic c, logic signed [DATA_W-1:0] v);
			queue_result_t r;
			int            pos;
			r.status = ST_DONE;
			if (c == CMD_INSERT) begin
				if (held_n >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new value goes behind every entry not larger than it
					pos = held_n;
					while (pos > 0 && held[pos-1] > v)
						pos--;
					for (int k = held_n; k > pos; k--)
						held[k] = held[k-1];
					held[pos] = v;
					held_n++;
				end
			end else begin
				pos = 0;
				while (pos < held_n && held[pos] != v)
					pos++;
				if (pos >= held_n) begin
					r.status = ST_NOMATCH;
				end else begin
					for (int k = pos; k + 1 < held_n; k++)
						held[k] = held[k+1];
					held_n--;
				end
			end
			r.entry_count = held_n[OCNT_W-1:0];
			r.head_valid  = held_n > 0;
			r.head_value  = (held_n > 0) ? held[0] : '0;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d count %0d",
					$time, got.status, got.entry_count);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("head_valid", want.head_valid, got.head_valid);
			compare_field("head_value", want.head_value, got.head_value);
		endfunction
	endclass

	spq_scoreboard sb = new();

	sorted_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_count (entry_count),
		.head_valid  (head_valid),
		.head_value  (head_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: check every result transaction at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status, entry_count, head_valid, head_value});
	end

	// Output side backpressure: a random stall before each result, with
	// stretches of always-ready in between.
	initial begin
		int stall;
		int taken;
		taken = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = ((taken / 40) % 3 == 0) ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
		end
	end

	// Hands one transaction to the block after an idle gap and notes it once taken.
	task automatic send_item(input logic c, input logic signed [DATA_W-1:0] v, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(c, v);
	endtask

	// Hold the input side off until the block has returned every result.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Small values four times in ten so duplicates and matches are common; the rest
	// hit the extremes or cover every bit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $signed($urandom_range(0, 8)) - 4;
			4: begin
				case ($urandom_range(0, 3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		int                       ins_pct;
		int                       gap;
		logic                     c;
		logic signed [DATA_W-1:0] v;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, fill with extremes and duplicates, overflow,
		// missed remove on a full list, oldest-duplicate removal, drain to empty.
		send_item(CMD_REMOVE, 5, 0);
		send_item(CMD_INSERT, VAL_MAX, 0);
		send_item(CMD_INSERT, VAL_MIN, 1);
		send_item(CMD_INSERT, 0, 0);
		send_item(CMD_INSERT, -1, 3);
		send_item(CMD_INSERT, 0, 0);
		send_item(CMD_INSERT, 7, 0);
		send_item(CMD_INSERT, 0, 2);
		send_item(CMD_INSERT, VAL_MAX, 0);
		send_item(CMD_INSERT, 3, 0);
		send_item(CMD_REMOVE, 42, 0);
		send_item(CMD_REMOVE, 0, 1);
		send_item(CMD_REMOVE, VAL_MIN, 0);
		send_item(CMD_REMOVE, VAL_MAX, 0);
		send_item(CMD_REMOVE, -1, 4);
		send_item(CMD_REMOVE, 0, 0);
		send_item(CMD_REMOVE, 0, 0);
		send_item(CMD_REMOVE, 7, 0);
		send_item(CMD_REMOVE, VAL_MAX, 0);
		send_item(CMD_REMOVE, VAL_MAX, 0);
		drain_results();

		// Random: the insert share changes every block so the list swings
		// between empty and full; removes mostly target a held entry.
		ins_pct = 50;
		for (int i = 0; i < 1550; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: ins_pct = 20;
					1: ins_pct = 50;
					default: ins_pct = 85;
				endcase
			end
			if (i % 400 == 399)
				drain_results();
			c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
			if (c == CMD_REMOVE && sb.held_n > 0 && $urandom_range(0, 3) != 0)
				v = sb.held[$urandom_range(0, sb.held_n - 1)];
			else
				v = pick_value();
			gap = ((i / 50) % 4 == 0) ? 0 : $urandom_range(0, 18);
			send_item(c, v, gap);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
